@@ sv/dltq_pkg.sv @@
// Package: constants, codes and types shared by the delta-list timer queue.
package dltq_pkg;

   localparam int TIMER_COUNT = 16;
   localparam int ID_W        = $clog2(TIMER_COUNT);
   localparam int PTR_W       = ID_W + 1;
   localparam int TIME_W      = 32;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;

   typedef logic [ID_W-1:0]     id_type;
   typedef logic [PTR_W-1:0]    ptr_type;
   typedef logic [TIME_W-1:0]   time_type;
   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam ptr_type NIL_PTR = ptr_type'(TIMER_COUNT);

   localparam cmd_type CMD_INSERT   = 2'd0;
   localparam cmd_type CMD_DELETE   = 2'd1;
   localparam cmd_type CMD_REBASE   = 2'd2;
   localparam cmd_type CMD_RESERVED = 2'd3;

   localparam status_type STATUS_OK           = 2'd0;
   localparam status_type STATUS_INS_ACTIVE   = 2'd1;
   localparam status_type STATUS_DEL_INACTIVE = 2'd2;

   typedef struct packed {
      logic       expired_valid;
      id_type     expired_id;
      logic       last;
      status_type status;
      logic       head_changed;
      time_type   head_delay;
      logic       list_empty;
   } rsp_word_type;

endpackage

@@ sv/dltq_if.sv @@
// Interfaces: command and result channels of the timer queue.
interface dltq_req_if;
   import dltq_pkg::*;
   logic     valid;
   logic     ready;
   cmd_type  command;
   id_type   timer_id;
   time_type delay;
   time_type new_time;
   modport source (output valid, command, timer_id, delay, new_time, input ready);
   modport sink   (input valid, command, timer_id, delay, new_time, output ready);
endinterface

interface dltq_rsp_if;
   import dltq_pkg::*;
   logic       valid;
   logic       ready;
   logic       expired_valid;
   id_type     expired_id;
   logic       last;
   status_type status;
   logic       head_changed;
   time_type   head_delay;
   logic       list_empty;
   modport source (output valid, expired_valid, expired_id, last, status, head_changed,
                   head_delay, list_empty, input ready);
   modport sink   (input valid, expired_valid, expired_id, last, status, head_changed,
                   head_delay, list_empty, output ready);
endinterface

@@ sv/delta_list_timer_queue_unit.sv @@
// Top level: delta-list timer queue with linked entries held in synchronous memories.
//
// req_if carries one command word: insert a timer with a delay from the base time,
// delete a timer, or rebase to a new time point. rsp_if returns result words: one per
// command, except a rebase, which gives one word per expired timer in expiry order
// (or a single word if none expired); last marks the final word of a command.
// Commands are taken one at a time. Insert walks the list one entry per cycle,
// then links the new entry in (S_WR2). Delete reads the entry and its successor,
// then relinks the neighbours. Rebase walks past the expired timers, then gives one
// word per cycle while the receiver takes them. The walk is set by the single read
// port of the entry memories. A rejected or unknown command goes straight to S_EMIT.
// The result register holds a finished word while the next command is taken.
// If the receiver stalls, rsp_if.valid and its word hold; a rebase with several
// expiries waits word by word, and no command is taken until the last is in the register.
// Reset clears the active flags, empties the list and zeroes the base time; the
// entry memories are not cleared and are read only for active timers.
module delta_list_timer_queue_unit (
   input  logic       clock,
   input  logic       reset,
   dltq_req_if.sink   req_if,
   dltq_rsp_if.source rsp_if
);
   import dltq_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_WALK = 3'd1;
   localparam logic [2:0] S_DEL  = 3'd2;
   localparam logic [2:0] S_DEL2 = 3'd3;
   localparam logic [2:0] S_WR2  = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   time_type delta_mem [TIMER_COUNT];
   ptr_type  next_mem  [TIMER_COUNT];
   ptr_type  prev_mem  [TIMER_COUNT];

   time_type delta_rd_ff;
   ptr_type  next_rd_ff, prev_rd_ff;
   id_type   rd_addr;

   logic     delta_we, next_we, prev_we;
   id_type   delta_wa, next_wa, prev_wa;
   time_type delta_wd;
   ptr_type  next_wd, prev_wd;

   logic [2:0]       state_ff, state_in;
   cmd_type          op_ff, op_in;
   id_type           tid_ff, tid_in;
   time_type         val_ff, val_in;
   ptr_type          cur_ff, cur_in, pre_ff, pre_in;
   status_type       status_ff, status_in;
   logic             changed_ff, changed_in;
   logic [TIMER_COUNT-1:0] active_ff, active_in;
   ptr_type          head_ff, head_in, tail_ff, tail_in;
   time_type         base_ff, base_in, hd_ff, hd_in;
   id_type           exp_ff [TIMER_COUNT];
   id_type           exp_in [TIMER_COUNT];
   logic [ID_W:0]    cnt_ff, cnt_in;
   id_type           idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic     accept, out_free, emit_last;
   time_type sum_d, diff_d;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign sum_d    = delta_rd_ff + val_ff;
   assign diff_d   = delta_rd_ff - val_ff;
   assign emit_last = (cnt_ff == '0) || (({1'b0, idx_ff} + 1'b1) == cnt_ff);

   assign req_if.ready         = (state_ff == S_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.expired_valid = rsp_word_ff.expired_valid;
   assign rsp_if.expired_id    = rsp_word_ff.expired_id;
   assign rsp_if.last          = rsp_word_ff.last;
   assign rsp_if.status        = rsp_word_ff.status;
   assign rsp_if.head_changed  = rsp_word_ff.head_changed;
   assign rsp_if.head_delay    = rsp_word_ff.head_delay;
   assign rsp_if.list_empty    = rsp_word_ff.list_empty;

   always_ff @(posedge clock) begin
      if (delta_we) delta_mem[delta_wa] <= delta_wd;
      if (next_we)  next_mem[next_wa]   <= next_wd;
      if (prev_we)  prev_mem[prev_wa]   <= prev_wd;
      delta_rd_ff <= delta_mem[rd_addr];
      next_rd_ff  <= next_mem[rd_addr];
      prev_rd_ff  <= prev_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tid_in       = tid_ff;
      val_in       = val_ff;
      cur_in       = cur_ff;
      pre_in       = pre_ff;
      status_in    = status_ff;
      changed_in   = changed_ff;
      active_in    = active_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      base_in      = base_ff;
      hd_in        = hd_ff;
      exp_in       = exp_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_word_in  = rsp_word_ff;
      rd_addr      = cur_ff[ID_W-1:0];
      delta_we = 1'b0; delta_wa = '0; delta_wd = '0;
      next_we  = 1'b0; next_wa  = '0; next_wd  = '0;
      prev_we  = 1'b0; prev_wa  = '0; prev_wd  = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = req_if.command;
               tid_in     = req_if.timer_id;
               status_in  = STATUS_OK;
               changed_in = 1'b0;
               cnt_in     = '0;
               idx_in     = '0;
               case (req_if.command)
                  CMD_INSERT: begin
                     if (active_ff[req_if.timer_id]) begin
                        status_in = STATUS_INS_ACTIVE;
                        state_in  = S_EMIT;
                     end else begin
                        val_in   = req_if.delay;
                        cur_in   = head_ff;
                        pre_in   = NIL_PTR;
                        rd_addr  = head_ff[ID_W-1:0];
                        state_in = S_WALK;
                     end
                  end
                  CMD_DELETE: begin
                     if (!active_ff[req_if.timer_id]) begin
                        status_in = STATUS_DEL_INACTIVE;
                        state_in  = S_EMIT;
                     end else begin
                        rd_addr  = req_if.timer_id;
                        state_in = S_DEL;
                     end
                  end
                  CMD_REBASE: begin
                     val_in     = req_if.new_time - base_ff;
                     base_in    = req_if.new_time;
                     cur_in     = head_ff;
                     rd_addr    = head_ff[ID_W-1:0];
                     changed_in = 1'b1;
                     state_in   = S_WALK;
                  end
                  default: state_in = S_EMIT;
               endcase
            end
         end
         S_WALK: begin
            if (op_ff == CMD_INSERT) begin
               if (cur_ff[ID_W] || (delta_rd_ff > val_ff)) begin
                  delta_we = 1'b1; delta_wa = tid_ff; delta_wd = val_ff;
                  next_we  = 1'b1; next_wa  = tid_ff; next_wd  = cur_ff;
                  prev_we  = 1'b1; prev_wa  = tid_ff; prev_wd  = pre_ff;
                  active_in[tid_ff] = 1'b1;
                  val_in = diff_d;
                  if (pre_ff[ID_W]) begin
                     head_in    = {1'b0, tid_ff};
                     hd_in      = val_ff;
                     changed_in = 1'b1;
                  end
                  if (cur_ff[ID_W]) tail_in = {1'b0, tid_ff};
                  state_in = S_WR2;
               end else begin
                  val_in  = val_ff - delta_rd_ff;
                  pre_in  = cur_ff;
                  cur_in  = next_rd_ff;
                  rd_addr = next_rd_ff[ID_W-1:0];
               end
            end else begin
               if (cur_ff[ID_W]) begin
                  head_in  = NIL_PTR;
                  tail_in  = NIL_PTR;
                  hd_in    = '0;
                  state_in = S_EMIT;
               end else if (delta_rd_ff > val_ff) begin
                  delta_we = 1'b1; delta_wa = cur_ff[ID_W-1:0]; delta_wd = diff_d;
                  prev_we  = 1'b1; prev_wa  = cur_ff[ID_W-1:0]; prev_wd  = NIL_PTR;
                  head_in  = cur_ff;
                  hd_in    = diff_d;
                  state_in = S_EMIT;
               end else begin
                  active_in[cur_ff[ID_W-1:0]] = 1'b0;
                  exp_in[cnt_ff[ID_W-1:0]]    = cur_ff[ID_W-1:0];
                  cnt_in  = cnt_ff + 1'b1;
                  val_in  = val_ff - delta_rd_ff;
                  cur_in  = next_rd_ff;
                  rd_addr = next_rd_ff[ID_W-1:0];
               end
            end
         end
         S_WR2: begin
            if (!cur_ff[ID_W]) begin
               delta_we = 1'b1; delta_wa = cur_ff[ID_W-1:0]; delta_wd = val_ff;
               prev_we  = 1'b1; prev_wa  = cur_ff[ID_W-1:0]; prev_wd  = {1'b0, tid_ff};
            end
            if (!pre_ff[ID_W]) begin
               next_we = 1'b1; next_wa = pre_ff[ID_W-1:0]; next_wd = {1'b0, tid_ff};
            end
            state_in = S_EMIT;
         end
         S_DEL: begin
            cur_in   = next_rd_ff;
            pre_in   = prev_rd_ff;
            val_in   = delta_rd_ff;
            rd_addr  = next_rd_ff[ID_W-1:0];
            state_in = S_DEL2;
         end
         S_DEL2: begin
            active_in[tid_ff] = 1'b0;
            if (!cur_ff[ID_W]) begin
               delta_we = 1'b1; delta_wa = cur_ff[ID_W-1:0]; delta_wd = sum_d;
               prev_we  = 1'b1; prev_wa  = cur_ff[ID_W-1:0]; prev_wd  = pre_ff;
            end else begin
               tail_in = pre_ff;
            end
            if (!pre_ff[ID_W]) begin
               next_we = 1'b1; next_wa = pre_ff[ID_W-1:0]; next_wd = cur_ff;
            end else begin
               head_in    = cur_ff;
               changed_in = 1'b1;
               hd_in      = cur_ff[ID_W] ? '0 : sum_d;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.expired_valid = (cnt_ff != '0);
               rsp_word_in.expired_id    = (cnt_ff != '0) ? exp_ff[idx_ff] : '0;
               rsp_word_in.last          = emit_last;
               rsp_word_in.status        = status_ff;
               rsp_word_in.head_changed  = changed_ff;
               rsp_word_in.head_delay    = head_ff[ID_W] ? '0 : hd_ff;
               rsp_word_in.list_empty    = head_ff[ID_W];
               if (emit_last) state_in = S_IDLE;
               else idx_in = idx_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         head_ff      <= NIL_PTR;
         tail_ff      <= NIL_PTR;
         base_ff      <= '0;
         hd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         base_ff      <= base_in;
         hd_ff        <= hd_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tid_ff      <= tid_in;
      val_ff      <= val_in;
      cur_ff      <= cur_in;
      pre_ff      <= pre_in;
      status_ff   <= status_in;
      changed_ff  <= changed_in;
      exp_ff      <= exp_in;
      rsp_word_ff <= rsp_word_in;
   end

`ifndef SYNTH
   a_head_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff[ID_W] == tail_ff[ID_W])
      else $error("head and tail disagree on empty list");

   a_empty_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (head_ff[ID_W] == (active_ff == '0)))
      else $error("empty list with active timers, or the reverse");

   a_ready_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready && state_ff == S_EMIT) |=> $stable(rsp_word_ff))
      else $error("result word overwritten while stalled");

   a_rebase_changed: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.command == CMD_REBASE) |=> changed_ff)
      else $error("rebase without head change");
`endif

endmodule
